// ===== src/dagu_pkg.sv =====
// Shared types, constants and constant functions of the distance attenuation gain unit.
package dagu_pkg;

	localparam int DIST_W    = 16;
	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 2;
	localparam int FRAC_BITS = 24;
	localparam int LOG_W     = 28;

	// Latencies of the log and exponential lanes, in register stages.
	// The exponential lane has the product, the offset sum, the divide by five,
	// the split, the factor chain and the final shift register.
	localparam int LOG_LAT = FRAC_BITS + 1;
	localparam int DIV5_STEPS = 5;
	localparam int EXP_LAT = 2 + DIV5_STEPS + 1 + FRAC_BITS + 1;

	localparam logic [17:0] GAIN_ONE     = 18'd32768;
	localparam logic [15:0] MIN_NEAR     = 16'd3;
	localparam logic [16:0] FAR_PAD      = 17'd256;
	localparam logic [15:0] ROLL_DEFAULT = 16'd4096;

	localparam logic [15:0] RESET_NEAR    = 16'd256;
	localparam logic [15:0] RESET_FAR     = 16'd12800;
	localparam logic [15:0] RESET_ROLLOFF = 16'd4096;

	typedef enum logic [1:0] {
		DM_NONE        = 2'd0,
		DM_LINEAR      = 2'd1,
		DM_INVERSE     = 2'd2,
		DM_EXPONENTIAL = 2'd3
	} dist_model_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODEL   = 2'd0,
		REG_NEAR    = 2'd1,
		REG_FAR     = 2'd2,
		REG_ROLLOFF = 2'd3
	} reg_index_t;

	// Effective configuration after the setter rules have been applied.
	typedef struct packed {
		dist_model_t model;
		logic [15:0] near;
		logic [16:0] far;
		logic [15:0] span;
		logic [15:0] rolloff;
	} dagu_cfg_t;

	// Per-item flags that travel alongside the arithmetic.
	typedef struct packed {
		logic near;
		logic lin_zero;
	} dagu_flags_t;

	// Integer square root, floor; evaluated at elaboration only.
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		logic [63:0] rem;
		rem = v;
		res = '0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (b > rem) b = b >> 2;
		end
		for (int k = 0; k < 32; k++) begin
			if (b != 0) begin
				if (rem >= res + b) begin
					rem = rem - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// Factor 2^-(2^-idx) in Q30, built by repeated square roots from one half.
	function automatic logic [29:0] exp_factor(input int unsigned idx);
		logic [63:0] c;
		c = 64'd1 << 29;
		for (int k = 0; k < FRAC_BITS; k++) begin
			if (k < idx) c = isqrt64(c << 30);
		end
		return c[29:0];
	endfunction

endpackage

// ===== src/dagu_stream_if.sv =====
// Valid/ready stream interfaces for the distance requests and the gain results.
interface dagu_dist_if import dagu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;

	modport source(output valid, output distance, input ready);
	modport sink(input valid, input distance, output ready);
endinterface

interface dagu_gain_if import dagu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [GAIN_W-1:0] gain;

	modport source(output valid, output gain, input ready);
	modport sink(input valid, input gain, output ready);
endinterface

// ===== src/dagu_delay.sv =====
// Enabled shift register that aligns data between pipeline lanes.
module dagu_delay import dagu_pkg::*; #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_s [DEPTH];

	// Every stage moves on together when the pipeline advances.
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) sr_s[i] <= sr_s[i-1];
		end
	end

	assign q = sr_s[DEPTH-1];

endmodule

// ===== src/dagu_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module dagu_divider import dagu_pkg::*; #(
	parameter int NUM_W = 46,
	parameter int DEN_W = 16,
	parameter int Q_W   = 31
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);

	logic [DEN_W-1:0] rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   low_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_st
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   low_in;
		logic [Q_W-1:0]   quo_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		// The first stage starts from the upper numerator bits, which are below the divisor.
		if (k == 0) begin : g_first
			assign rem_in = DEN_W'(num[NUM_W-1:Q_W]);
			assign den_in = den;
			assign low_in = num[Q_W-1:0];
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign low_in = low_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// Shift in the next numerator bit and subtract where it fits.
		assign trial = {rem_in, low_in[Q_W-1]};
		assign ge    = trial >= {1'b0, den_in};
		assign diff  = ge ? (trial - {1'b0, den_in}) : trial;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_in[Q_W-2:0], ge};
			end
		end

		if (k < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= diff[DEN_W-1:0];
					den_s[k] <= den_in;
					low_s[k] <= {low_in[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[Q_W-1];

endmodule

// ===== src/dagu_log2.sv =====
// Pipelined base-two logarithm in Q24 by normalising and repeated squaring.
module dagu_log2 import dagu_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [15:0]      v,
	output logic [LOG_W-1:0] lg
);

	logic [3:0]       msb;
	logic [30:0]      m_norm;
	logic [30:0]      m_s   [FRAC_BITS];
	logic [LOG_W-1:0] acc_s [FRAC_BITS+1];

	// Find the leading one and scale the mantissa into [1, 2) in Q30.
	always_comb begin
		msb = '0;
		for (int i = 1; i < 16; i++) begin
			if (v[i]) msb = 4'(i);
		end
		m_norm = 31'(v) << (5'd30 - {1'b0, msb});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]   <= m_norm;
			acc_s[0] <= {msb, {FRAC_BITS{1'b0}}};
		end
	end

	// One fraction bit per stage: square, and halve where the square reaches two.
	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] t;

		assign sq = 62'(m_s[k]) * 62'(m_s[k]);
		assign t  = sq[61:30];

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k+1] <= acc_s[k] |
					(t[31] ? (LOG_W'(1) << (FRAC_BITS - 1 - k)) : LOG_W'(0));
			end
		end

		if (k < FRAC_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) m_s[k+1] <= t[31] ? t[31:1] : t[30:0];
			end
		end
	end

	assign lg = acc_s[FRAC_BITS];

endmodule

// ===== src/dagu_exp2.sv =====
// Exponential lane: scales the log ratio by 0.85 times rolloff and raises two to its negative.
module dagu_exp2 import dagu_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [LOG_W-1:0] lg,
	input  logic [15:0]      rolloff,
	output logic [16:0]      gain
);

	logic [43:0] prod_s1;
	logic [48:0] scaled;
	logic [2:0]  rem_s  [DIV5_STEPS+1];
	logic [39:0] quo_s  [DIV5_STEPS+1];
	logic [39:0] rest_s [DIV5_STEPS];
	logic [30:0] acc_s  [FRAC_BITS+1];
	logic [23:0] frac_s [FRAC_BITS];
	logic [10:0] ip_s   [FRAC_BITS+1];
	logic [5:0]  sh;
	logic [46:0] rsum;
	logic [46:0] shifted;

	// Log ratio times rolloff.
	always_ff @(posedge clk) begin
		if (en) prod_s1 <= 44'(lg) * 44'(rolloff);
	end

	// Times 17 with the rounding offset, then the power-of-two part of the divide by 81920.
	assign scaled = (49'(prod_s1) << 4) + 49'(prod_s1) + 49'd40960;

	always_ff @(posedge clk) begin
		if (en) begin
			rest_s[0] <= 40'(scaled[48:14]);
			rem_s[0]  <= '0;
			quo_s[0]  <= '0;
		end
	end

	// Divide by five, one byte per stage, by a reciprocal that is exact below 1280.
	for (genvar j = 0; j < DIV5_STEPS; j++) begin : g_div5
		logic [10:0] n;
		logic [22:0] nq;
		logic [7:0]  qd;
		logic [10:0] back;

		assign n    = {rem_s[j], rest_s[j][39:32]};
		assign nq   = 23'(n) * 23'd3277;
		assign qd   = nq[21:14];
		assign back = n - 11'(qd) * 11'd5;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= back[2:0];
				quo_s[j+1] <= {quo_s[j][31:0], qd};
			end
		end

		if (j < DIV5_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) rest_s[j+1] <= {rest_s[j][31:0], 8'd0};
			end
		end
	end

	// Split the scaled exponent into its whole and fractional parts.
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0]  <= 31'd1 << 30;
			frac_s[0] <= quo_s[DIV5_STEPS][23:0];
			ip_s[0]   <= quo_s[DIV5_STEPS][34:24];
		end
	end

	// Multiply in one constant factor per fraction bit that is set.
	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_exp
		localparam logic [29:0] FACTOR = exp_factor(k + 1);
		logic [61:0] p;

		assign p = 62'(acc_s[k]) * 62'(FACTOR);

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k+1] <= frac_s[k][FRAC_BITS-1-k] ? p[60:30] : acc_s[k];
				ip_s[k+1]  <= ip_s[k];
			end
		end

		if (k < FRAC_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) frac_s[k+1] <= frac_s[k];
			end
		end
	end

	// Rounding shift by the whole part; a large whole part leaves nothing.
	assign sh      = 6'(ip_s[FRAC_BITS][4:0]) + 6'd15;
	assign rsum    = 47'(acc_s[FRAC_BITS]) + (47'd1 << (sh - 6'd1));
	assign shifted = rsum >> sh;

	always_ff @(posedge clk) begin
		if (en) gain <= (ip_s[FRAC_BITS] > 11'd31) ? 17'd0 : shifted[16:0];
	end

endmodule

// ===== src/distance_attenuation_gain_unit.sv =====
// Path: front stages, model lanes delayed to match, clamp register, output register.
// Throughput: one distance per cycle while the skid entry is free, set by the fully
// pipelined dividers and the squaring and product stages of the log and exponential
// lanes. A full output register and skid entry stall the whole pipeline without loss.
// Reset empties the pipeline and loads the registers with inverse model, 1 m, 50 m, 1.0.
module distance_attenuation_gain_unit import dagu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	dagu_dist_if.sink            din,
	dagu_gain_if.source          dout
);

	localparam int LIN_NUM_W = 46;
	localparam int LIN_Q_W   = 31;
	localparam int INV_NUM_W = 44;
	localparam int INV_DEN_W = 33;
	localparam int INV_Q_W   = 16;
	localparam int S_DIV_IN  = 4;
	localparam int S_LIN_G   = S_DIV_IN + LIN_Q_W + 2;
	localparam int S_INV     = S_DIV_IN + INV_Q_W;
	localparam int S_EXP     = 1 + LOG_LAT + EXP_LAT;
	localparam int PIPE_LAT  = S_EXP + 1;

	logic [1:0]  model_q;
	logic [15:0] near_q;
	logic [15:0] far_q;
	logic [15:0] rolloff_q;
	dagu_cfg_t   cfg;

	logic                en;
	logic                fire;
	logic                push;
	logic                pop;
	logic [PIPE_LAT-1:0] vld_q;

	logic [15:0] d_s1;
	logic [15:0] dl_s2;
	logic        near_s2;
	logic        far_s2;
	logic [31:0] rdl_s3;
	logic        near_s3;
	logic        far_s3;
	logic [30:0] full;
	logic [34:0] drop;
	logic        lin_zero;
	logic [34:0] lin_diff;
	logic [32:0] inv_den;
	logic [LIN_NUM_W-1:0] lin_num_s4;
	logic [INV_NUM_W-1:0] inv_num_s4;
	logic [INV_DEN_W-1:0] inv_den_s4;
	dagu_flags_t flags_s4;
	dagu_flags_t flags_d;

	logic [LIN_Q_W-1:0] lin_x;
	logic [61:0]        x_sq;
	logic [30:0]        x_s36;
	logic [30:0]        x2_s36;
	logic [31:0]        smooth_k;
	logic [62:0]        smooth_p;
	logic [17:0]        lin_g_s37;
	logic [17:0]        lin_g_d;
	logic [INV_Q_W-1:0] inv_q;
	logic [INV_Q_W-1:0] inv_q_d;

	logic [LOG_W-1:0] ld;
	logic [LOG_W-1:0] lmn;
	logic [LOG_W-1:0] lratio;
	logic [16:0]      exp_g;
	logic [17:0]      pick;
	logic [15:0]      gain_s60;

	logic [15:0] main_q;
	logic        main_vld_q;
	logic [15:0] spare_q;
	logic        spare_vld_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q   <= DM_INVERSE;
			near_q    <= RESET_NEAR;
			far_q     <= RESET_FAR;
			rolloff_q <= RESET_ROLLOFF;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_MODEL:   model_q   <= cfg_data[1:0];
				REG_NEAR:    near_q    <= cfg_data;
				REG_FAR:     far_q     <= cfg_data;
				REG_ROLLOFF: rolloff_q <= cfg_data;
			endcase
		end
	end

	// Setter rules: near floor, far padding when not above near, default rolloff.
	always_comb begin
		cfg.model   = dist_model_t'(model_q);
		cfg.near    = (near_q < MIN_NEAR) ? MIN_NEAR : near_q;
		cfg.far     = (far_q > cfg.near) ? {1'b0, far_q} : ({1'b0, cfg.near} + FAR_PAD);
		cfg.span    = 16'(cfg.far - {1'b0, cfg.near});
		cfg.rolloff = (rolloff_q == 16'd0) ? ROLL_DEFAULT : rolloff_q;
	end

	// The pipeline moves whenever the skid entry is free.
	assign en        = !spare_vld_q;
	assign din.ready = en;
	assign fire      = din.valid && en;
	assign push      = en && vld_q[PIPE_LAT-1];
	assign pop       = main_vld_q && dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], fire};
		end
	end

	// Front stages: distance beyond near, far test, and rolloff times excess distance.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= din.distance;
			near_s2 <= d_s1 <= cfg.near;
			far_s2  <= {1'b0, d_s1} >= cfg.far;
			dl_s2   <= (d_s1 <= cfg.near) ? 16'd0 : (d_s1 - cfg.near);
			rdl_s3  <= 32'(dl_s2) * 32'(cfg.rolloff);
			near_s3 <= near_s2;
			far_s3  <= far_s2;
		end
	end

	// Dividend and divisor set-up for the linear and inverse models.
	assign full     = {cfg.span, 15'd0};
	assign drop     = {rdl_s3, 3'd0};
	assign lin_zero = far_s3 || (drop >= 35'(full));
	assign lin_diff = 35'(full) - drop;
	assign inv_den  = {5'd0, cfg.near, 12'd0} + 33'(rdl_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			lin_num_s4 <= lin_zero ? '0 :
				(LIN_NUM_W'(lin_diff[30:0]) << 15) + LIN_NUM_W'(cfg.span >> 1);
			inv_num_s4 <= (INV_NUM_W'(cfg.near) << 27) + INV_NUM_W'(inv_den >> 1);
			inv_den_s4 <= inv_den;
			flags_s4   <= '{near: near_s3, lin_zero: lin_zero};
		end
	end

	dagu_divider #(.NUM_W(LIN_NUM_W), .DEN_W(16), .Q_W(LIN_Q_W)) u_lin_div (
		.clk (clk),
		.en  (en),
		.num (lin_num_s4),
		.den (cfg.span),
		.quo (lin_x)
	);

	dagu_divider #(.NUM_W(INV_NUM_W), .DEN_W(INV_DEN_W), .Q_W(INV_Q_W)) u_inv_div (
		.clk (clk),
		.en  (en),
		.num (inv_num_s4),
		.den (inv_den_s4),
		.quo (inv_q)
	);

	// Smoothstep on the linear fraction: square, then times three minus twice x.
	assign x_sq     = 62'(lin_x) * 62'(lin_x);
	assign smooth_k = (32'd3 << 30) - {x_s36, 1'b0};
	assign smooth_p = 63'(x2_s36) * 63'(smooth_k);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s36     <= lin_x;
			x2_s36    <= 31'((x_sq + (62'd1 << 29)) >> 30);
			lin_g_s37 <= 18'((smooth_p + (63'd1 << 44)) >> 45);
		end
	end

	// Exponential lane: log of distance and of near, then the power of two.
	dagu_log2 u_log_d (
		.clk (clk),
		.en  (en),
		.v   (d_s1),
		.lg  (ld)
	);

	dagu_log2 u_log_near (
		.clk (clk),
		.en  (en),
		.v   (cfg.near),
		.lg  (lmn)
	);

	assign lratio = (ld >= lmn) ? (ld - lmn) : '0;

	dagu_exp2 u_exp (
		.clk     (clk),
		.en      (en),
		.lg      (lratio),
		.rolloff (cfg.rolloff),
		.gain    (exp_g)
	);

	// Bring the shorter lanes level with the exponential one.
	dagu_delay #(.W(18), .DEPTH(S_EXP - S_LIN_G)) u_lin_dly (
		.clk (clk),
		.en  (en),
		.d   (lin_g_s37),
		.q   (lin_g_d)
	);

	dagu_delay #(.W(INV_Q_W), .DEPTH(S_EXP - S_INV)) u_inv_dly (
		.clk (clk),
		.en  (en),
		.d   (inv_q),
		.q   (inv_q_d)
	);

	dagu_delay #(.W($bits(dagu_flags_t)), .DEPTH(S_EXP - S_DIV_IN)) u_flag_dly (
		.clk (clk),
		.en  (en),
		.d   (flags_s4),
		.q   (flags_d)
	);

	// Model selection, near field and the final clamp to unity.
	always_comb begin
		priority if (cfg.model == DM_NONE || flags_d.near) begin
			pick = GAIN_ONE;
		end else begin
			unique case (cfg.model)
				DM_LINEAR:      pick = flags_d.lin_zero ? 18'd0 : lin_g_d;
				DM_INVERSE:     pick = 18'(inv_q_d);
				DM_EXPONENTIAL: pick = 18'(exp_g);
				DM_NONE:        pick = GAIN_ONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) gain_s60 <= (pick > GAIN_ONE) ? GAIN_ONE[15:0] : pick[15:0];
	end

	// Output register with one skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q      <= '0;
			main_vld_q  <= 1'b0;
			spare_q     <= '0;
			spare_vld_q <= 1'b0;
		end else if (pop) begin
			if (spare_vld_q) begin
				main_q      <= spare_q;
				spare_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
				main_q     <= gain_s60;
			end
		end else if (push) begin
			if (!main_vld_q) begin
				main_vld_q <= 1'b1;
				main_q     <= gain_s60;
			end else begin
				spare_vld_q <= 1'b1;
				spare_q     <= gain_s60;
			end
		end
	end

	assign dout.valid = main_vld_q;
	assign dout.gain  = main_q;

endmodule

// ===== test/distance_attenuation_gain_unit_test.sv =====
// Self-checking testbench for the distance attenuation gain unit.
module distance_attenuation_gain_unit_test;
	import dagu_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 70;
	localparam int PHASE_ITEMS = 47;

	typedef struct {
		dist_model_t model;
		logic [15:0] distance;
		bit          known;
		logic [15:0] gain;
	} gain_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	dagu_dist_if din();
	dagu_gain_if dout();

	distance_attenuation_gain_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.din(din),
		.dout(dout)
	);

	// Predictor copy of the registers.
	dist_model_t cur_model;
	logic [15:0] cur_near;
	logic [15:0] cur_far;
	logic [15:0] cur_roll;

	logic [15:0] gain_q[$];
	int          errors;
	int          quiet_cycles;
	int          hold_cnt;
	bit          pressure_req;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Floor integer square root.
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Base-two logarithm in Q24 by normalising and repeated squaring.
	function automatic longint unsigned log2_fix(longint unsigned v);
		int unsigned     p;
		longint unsigned m;
		longint unsigned acc;
		p = 0;
		while (p < 31 && (v >> (p + 1)) != 0) p++;
		m = v << (30 - p);
		acc = longint'(p) << 24;
		for (int i = 23; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				acc = acc | (64'd1 << i);
				m = m >> 1;
			end
		end
		return acc;
	endfunction

	// Two to the power of minus y, y in Q24, result in Q15.
	function automatic longint unsigned pow2_neg(longint unsigned y);
		longint unsigned ip;
		longint unsigned f;
		longint unsigned acc;
		longint unsigned c;
		longint unsigned sh;
		ip = y >> 24;
		f = y & ((64'd1 << 24) - 1);
		acc = 64'd1 << 30;
		c = 64'd1 << 29;
		for (int i = 1; i <= 24; i++) begin
			c = int_sqrt(c << 30);
			if ((f >> (24 - i)) & 1) acc = (acc * c) >> 30;
		end
		if (ip > 31) return 0;
		sh = 15 + ip;
		if (sh > 46) return 0;
		return (acc + (64'd1 << (sh - 1))) >> sh;
	endfunction

	// Expected gain for one distance under the current registers.
	function automatic logic [15:0] attenuation(logic [15:0] d);
		longint unsigned mn, mx, r, dl, sp, g;
		longint unsigned full, drop, x, x2, s, num, den, lg, y;
		mn = (cur_near < MIN_NEAR) ? 64'(MIN_NEAR) : 64'(cur_near);
		mx = (64'(cur_far) > mn) ? 64'(cur_far) : mn + 256;
		r = (cur_roll != 0) ? 64'(cur_roll) : 64'(ROLL_DEFAULT);
		if (cur_model == DM_NONE) return 16'(GAIN_ONE);
		if (64'(d) <= mn) return 16'(GAIN_ONE);
		dl = 64'(d) - mn;
		sp = mx - mn;
		case (cur_model)
			DM_LINEAR: begin
				if (64'(d) >= mx) return 16'd0;
				full = 64'd32768 * sp;
				drop = 64'd8 * r * dl;
				if (drop >= full) return 16'd0;
				x = (((full - drop) << 15) + sp / 2) / sp;
				x2 = (x * x + (64'd1 << 29)) >> 30;
				s = x2 * (64'd3 * (64'd1 << 30) - 64'd2 * x);
				g = (s + (64'd1 << 44)) >> 45;
			end
			DM_INVERSE: begin
				num = mn << 27;
				den = mn * 4096 + r * dl;
				g = (num + den / 2) / den;
			end
			default: begin
				lg = log2_fix(64'(d)) - log2_fix(mn);
				y = (lg * r * 17 + 40960) / 81920;
				g = pow2_neg(y);
			end
		endcase
		if (g > 32768) g = 32768;
		return 16'(g);
	endfunction

	// Register write; the predictor copy follows.
	task automatic write_reg(reg_index_t idx, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_MODEL:   cur_model = dist_model_t'(v[1:0]);
			REG_NEAR:    cur_near = v;
			REG_FAR:     cur_far = v;
			REG_ROLLOFF: cur_roll = v;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every expected gain has come back.
	task automatic drain();
		while (gain_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Offer one distance request, after a random gap, and record its gain on acceptance.
	task automatic send_request(logic [15:0] d, bit known, logic [15:0] g);
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		if (no_idle || pick < 55) gap = 0;
		else if (pick < 95) gap = $urandom_range(1, 3);
		else gap = $urandom_range(10, 30);
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din.valid <= 1'b1;
		din.distance <= d;
		do @(posedge clk); while (!din.ready);
		gain_q.push_back(known ? g : attenuation(d));
	endtask

	// Random distance, weighted towards the near and far edges.
	function automatic logic [15:0] pick_distance();
		int unsigned mn;
		int unsigned sel;
		mn = (cur_near < MIN_NEAR) ? MIN_NEAR : cur_near;
		sel = $urandom_range(0, 9);
		if (sel < 5) return 16'($urandom);
		if (sel < 7) return 16'(mn + $urandom_range(0, 4) - 2);
		if (sel < 9) return 16'(cur_far + $urandom_range(0, 4) - 2);
		return 16'(mn + $urandom_range(0, 2000));
	endfunction

	// Receiver: random stalls, an occasional long one, and one forced hold-off.
	initial begin
		dout.ready = 1'b0;
		hold_cnt = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pressure_req) begin
				pressure_req = 1'b0;
				hold_cnt = 250;
			end else if (hold_cnt > 0) begin
				hold_cnt--;
			end else if (!no_idle) begin
				int r;
				r = $urandom_range(0, 99);
				if (r < 2) hold_cnt = $urandom_range(10, 40);
				else if (r < 25) hold_cnt = $urandom_range(1, 3);
			end
			dout.ready <= (hold_cnt == 0);
		end
	end

	// Compare each gain with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready) begin
			if (gain_q.size() == 0) begin
				$display("%0t: unexpected gain, actual %0d", $time, dout.gain);
				errors++;
			end else begin
				logic [15:0] want;
				want = gain_q.pop_front();
				if (dout.gain !== want) begin
					$display("%0t: gain mismatch, expected %0d, actual %0d",
						$time, want, dout.gain);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no request or result accepted.
	always @(posedge clk) begin
		if ((din.valid && din.ready) || (dout.valid && dout.ready)) begin
			quiet_cycles = 0;
		end else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		gain_row_t rows[$];
		logic [15:0] ph_model[$];
		logic [15:0] ph_near[$];
		logic [15:0] ph_far[$];
		logic [15:0] ph_roll[$];

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODEL;
		cfg_data = '0;
		din.valid = 1'b0;
		din.distance = '0;
		errors = 0;
		quiet_cycles = 0;
		pressure_req = 1'b0;
		no_idle = 1'b0;
		cur_model = DM_INVERSE;
		cur_near = RESET_NEAR;
		cur_far = RESET_FAR;
		cur_roll = RESET_ROLLOFF;

		// Directed rows under the reset registers, only the model changed.
		rows = '{
			'{DM_INVERSE, 16'd0, 1, 16'd32768},
			'{DM_INVERSE, 16'd256, 1, 16'd32768},
			'{DM_INVERSE, 16'd512, 1, 16'd16384},
			'{DM_INVERSE, 16'd1, 1, 16'd32768},
			'{DM_INVERSE, 16'd257, 0, 16'd0},
			'{DM_INVERSE, 16'd65535, 0, 16'd0},
			'{DM_NONE, 16'd65535, 1, 16'd32768},
			'{DM_NONE, 16'd0, 1, 16'd32768},
			'{DM_NONE, 16'd1000, 1, 16'd32768},
			'{DM_LINEAR, 16'd12800, 1, 16'd0},
			'{DM_LINEAR, 16'd65535, 1, 16'd0},
			'{DM_LINEAR, 16'd256, 1, 16'd32768},
			'{DM_LINEAR, 16'd257, 0, 16'd0},
			'{DM_LINEAR, 16'd6528, 0, 16'd0},
			'{DM_LINEAR, 16'd12799, 0, 16'd0},
			'{DM_EXPONENTIAL, 16'd256, 1, 16'd32768},
			'{DM_EXPONENTIAL, 16'd0, 1, 16'd32768},
			'{DM_EXPONENTIAL, 16'd257, 0, 16'd0},
			'{DM_EXPONENTIAL, 16'd512, 0, 16'd0},
			'{DM_EXPONENTIAL, 16'd1024, 0, 16'd0},
			'{DM_EXPONENTIAL, 16'd65535, 0, 16'd0}
		};

		// Register settings per phase, extremes and setter corner cases first.
		ph_model = '{DM_LINEAR, DM_EXPONENTIAL, DM_NONE, DM_LINEAR, DM_INVERSE,
			DM_EXPONENTIAL, DM_EXPONENTIAL, DM_LINEAR, DM_INVERSE, DM_LINEAR};
		ph_near = '{16'd256, 16'd256, 16'd1000, 16'd0, 16'd65535,
			16'd3, 16'd3, 16'd3, 16'd3, 16'd5000};
		ph_far = '{16'd12800, 16'd12800, 16'd2000, 16'd0, 16'd65535,
			16'd65535, 16'd0, 16'd65535, 16'd10, 16'd3000};
		ph_roll = '{16'd4096, 16'd4096, 16'd100, 16'd0, 16'd65535,
			16'd1, 16'd65535, 16'd65535, 16'd1, 16'd2048};
		for (int k = 0; k < 6; k++) begin
			ph_model.push_back(16'($urandom_range(0, 3)));
			ph_near.push_back(16'($urandom_range(0, 4000)));
			ph_far.push_back(16'($urandom));
			ph_roll.push_back(16'($urandom));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		foreach (rows[i]) begin
			if (rows[i].model != cur_model) begin
				din.valid <= 1'b0;
				drain();
				write_reg(REG_MODEL, 16'(rows[i].model));
			end
			send_request(rows[i].distance, rows[i].known, rows[i].gain);
		end

		// Random part, one register setting per phase; the hold-off phase runs
		// long enough to fill the whole pipeline.
		foreach (ph_model[p]) begin
			din.valid <= 1'b0;
			drain();
			write_reg(REG_MODEL, ph_model[p]);
			write_reg(REG_NEAR, ph_near[p]);
			write_reg(REG_FAR, ph_far[p]);
			write_reg(REG_ROLLOFF, ph_roll[p]);
			no_idle = (p % 4 == 1);
			for (int n = 0; n < ((p == 2) ? 2 * PHASE_ITEMS : PHASE_ITEMS); n++) begin
				if (p == 2 && n == 5) pressure_req = 1'b1;
				send_request(pick_distance(), 0, 16'd0);
			end
		end
		din.valid <= 1'b0;
		no_idle = 1'b0;

		while (gain_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
